// ----- src/pnfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pnfe_pkg
// Shared types and constants for the Petri net firing engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pnfe_pkg;
  localparam int PLACES      = 16;
  localparam int TRANSITIONS = 16;
  localparam int TOKEN_BITS  = 8;
  localparam int PW = $clog2(PLACES);
  localparam int TW = $clog2(TRANSITIONS);

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_FIRE  = 3'd3,
    OP_QUERY = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_EN  = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  trans_index;
    logic [3:0]  place_index;
    logic [15:0] pre_mask;
    logic [15:0] context_mask;
    logic [15:0] post_mask;
    logic [7:0]  token_value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_CONS, S_PROD, S_ENAB, S_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- src/petri_net_firing_engine_unit.sv -----
// ----------------------------------------------------------------------------
// petri_net_firing_engine_unit
// Petri net token game with read arcs, unit arc weight, saturating counts.
// ----------------------------------------------------------------------------
// Usage: one input beat carries an op (load arcs, write/read a place count,
// fire, query). Every beat yields exactly one result beat with a status,
// the enabled set after the operation and the read count (zero otherwise).
// A two-entry queue decouples the input side from the executor, so up to
// two beats are taken while a result still waits on out_ready.
// Steps: most ops pass idle, decode, an enable walk over the transitions
// and a result state; a fire also walks the places to check them and, if
// it succeeds, to consume and then produce, one place a cycle. The executor
// takes a new beat only in idle, once the last result has been taken.
// Reset (rst_n low, synchronous) clears marking, arcs and the queue.
// A stalled receiver holds the result; the queue then fills and in_ready
// drops.
// ----------------------------------------------------------------------------
`default_nettype none
module petri_net_firing_engine_unit import pnfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [3:0]  in_trans_index,
  input  wire logic [3:0]  in_place_index,
  input  wire logic [15:0] in_pre_mask,
  input  wire logic [15:0] in_context_mask,
  input  wire logic [15:0] in_post_mask,
  input  wire logic [7:0]  in_token_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_enabled_set,
  output logic [7:0]       out_token_read
);
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  assign in_cmd = '{op: in_op, trans_index: in_trans_index,
                    place_index: in_place_index, pre_mask: in_pre_mask,
                    context_mask: in_context_mask, post_mask: in_post_mask,
                    token_value: in_token_value};

  pnfe_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  pnfe_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .out_status, .out_enabled_set, .out_token_read
  );
endmodule
`default_nettype wire

// ----- src/pnfe_front.sv -----
// ----------------------------------------------------------------------------
// pnfe_front
// Input stage and two-entry command queue toward the executor.
// ----------------------------------------------------------------------------
`default_nettype none
module pnfe_front import pnfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire cmd_t        in_cmd,
  output logic             q_valid,
  input  wire logic        q_ready,
  output cmd_t             q_cmd
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- src/pnfe_back.sv -----
// ----------------------------------------------------------------------------
// pnfe_back
// Executor: walks places and transitions one per cycle, holds result.
// ----------------------------------------------------------------------------
`default_nettype none
module pnfe_back import pnfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire cmd_t        q_cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_enabled_set,
  output logic [7:0]       out_token_read
);
  localparam logic [TOKEN_BITS-1:0] MAXC = {TOKEN_BITS{1'b1}};

  logic [TOKEN_BITS-1:0] tok_r [PLACES];
  logic [PLACES-1:0]     cons_r [TRANSITIONS];
  logic [PLACES-1:0]     rd_r   [TRANSITIONS];
  logic [PLACES-1:0]     prod_r [TRANSITIONS];

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  logic [PW:0] pi_r;
  logic [TW:0] ti_r;
  logic        ok_r;
  logic [1:0]  st_r;
  logic [15:0] en_r;
  logic [7:0]  tr_r;

  logic [PW-1:0] pidx;
  logic [TW-1:0] tidx, ctidx;
  logic [PLACES-1:0] need_t;

  assign pidx  = pi_r[PW-1:0];
  assign tidx  = ti_r[TW-1:0];
  assign ctidx = cmd_r.trans_index[TW-1:0];
  assign need_t = cons_r[tidx] | rd_r[tidx];
  assign q_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_enabled_set = en_r;
  assign out_token_read = tr_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (cmd_r.op == OP_FIRE && {28'd0, cmd_r.trans_index} < TRANSITIONS) begin
          if (!ok_r) state_nxt = S_ENAB;
          else if (pi_r == (PW+1)'(PLACES)) state_nxt = S_CONS;
          else state_nxt = S_CHECK;
        end else state_nxt = S_ENAB;
      end
      S_CONS: state_nxt = (pi_r == (PW+1)'(PLACES-1)) ? S_PROD : S_CONS;
      S_PROD: state_nxt = (pi_r == (PW+1)'(PLACES-1)) ? S_ENAB : S_PROD;
      S_ENAB: state_nxt = (ti_r == (TW+1)'(TRANSITIONS)) ? S_OUT : S_ENAB;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < PLACES; i++) tok_r[i] <= '0;
      for (int i = 0; i < TRANSITIONS; i++) begin
        cons_r[i] <= '0; rd_r[i] <= '0; prod_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (q_valid) begin
          cmd_r <= q_cmd; pi_r <= '0; ti_r <= '0; ok_r <= 1'b1;
          st_r <= ST_OK; en_r <= '0; tr_r <= '0;
        end
        S_CHECK: begin
          case (cmd_r.op)
            OP_LOAD: if ({28'd0, cmd_r.trans_index} < TRANSITIONS) begin
              cons_r[ctidx] <= cmd_r.pre_mask[PLACES-1:0];
              rd_r[ctidx]   <= cmd_r.context_mask[PLACES-1:0];
              prod_r[ctidx] <= cmd_r.post_mask[PLACES-1:0];
            end
            OP_WRITE: if ({28'd0, cmd_r.place_index} < PLACES)
              tok_r[cmd_r.place_index[PW-1:0]] <= TOKEN_BITS'(cmd_r.token_value);
            OP_READ: if ({28'd0, cmd_r.place_index} < PLACES)
              tr_r <= 8'(tok_r[cmd_r.place_index[PW-1:0]]);
            OP_FIRE: begin
              if ({28'd0, cmd_r.trans_index} >= TRANSITIONS) st_r <= ST_NOT_EN;
              else if (pi_r == (PW+1)'(PLACES)) pi_r <= '0;
              else if (ok_r) begin
                if ((cons_r[ctidx][pidx] | rd_r[ctidx][pidx]) && tok_r[pidx] == '0) begin
                  ok_r <= 1'b0; st_r <= ST_NOT_EN;
                end
                pi_r <= pi_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_CONS: begin
          if (cons_r[ctidx][pidx]) tok_r[pidx] <= tok_r[pidx] - 1'b1;
          pi_r <= (pi_r == (PW+1)'(PLACES-1)) ? '0 : pi_r + 1'b1;
        end
        S_PROD: begin
          if (prod_r[ctidx][pidx]) begin
            if (tok_r[pidx] == MAXC) st_r <= ST_SAT;
            else tok_r[pidx] <= tok_r[pidx] + 1'b1;
          end
          pi_r <= pi_r + 1'b1;
        end
        S_ENAB: if (ti_r != (TW+1)'(TRANSITIONS)) begin
          // check one transition per cycle against all place counts
          if (ti_r < (TW+1)'(16)) begin
            logic hit;
            hit = 1'b1;
            for (int p = 0; p < PLACES; p++)
              if (need_t[p] && tok_r[p] == '0) hit = 1'b0;
            en_r[4'(ti_r)] <= hit;
          end
          ti_r <= ti_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb_petri_net_firing_engine_unit.sv -----
// ----------------------------------------------------------------------------
// tb_petri_net_firing_engine_unit
// Self-checking bench for the Petri net firing engine. A predictor of the
// marking and arc tables computes the expected result of every accepted input
// beat; results are checked in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class marking_scoreboard;
  logic [7:0]  tokens [16];
  logic [15:0] consume [16];
  logic [15:0] test_arcs [16];
  logic [15:0] produce [16];
  logic [1:0]  exp_status [$];
  logic [15:0] exp_enabled [$];
  logic [7:0]  exp_read [$];
  int          errors;

  function new();
    for (int i = 0; i < 16; i++) begin
      tokens[i] = '0; consume[i] = '0; test_arcs[i] = '0; produce[i] = '0;
    end
    errors = 0;
  endfunction

  function bit can_fire(int t);
    logic [15:0] need;
    need = consume[t] | test_arcs[t];
    for (int p = 0; p < 16; p++)
      if (need[p] && tokens[p] == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one op to the marking and queue the result it yields.
  function void note_input(logic [2:0] op, logic [3:0] t, logic [3:0] p,
                           logic [15:0] pre, logic [15:0] ctx,
                           logic [15:0] post, logic [7:0] val);
    logic [1:0]  st;
    logic [7:0]  rd;
    logic [15:0] en;
    st = pnfe_pkg::ST_OK;
    rd = '0;
    case (op)
      pnfe_pkg::OP_LOAD: begin
        consume[t] = pre; test_arcs[t] = ctx; produce[t] = post;
      end
      pnfe_pkg::OP_WRITE: tokens[p] = val;
      pnfe_pkg::OP_READ:  rd = tokens[p];
      pnfe_pkg::OP_FIRE: begin
        if (!can_fire(t)) st = pnfe_pkg::ST_NOT_EN;
        else begin
          for (int i = 0; i < 16; i++) if (consume[t][i]) tokens[i] -= 8'd1;
          for (int i = 0; i < 16; i++)
            if (produce[t][i]) begin
              if (tokens[i] == 8'hff) st = pnfe_pkg::ST_SAT;
              else tokens[i] += 8'd1;
            end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 16; i++) en[i] = can_fire(i);
    exp_status  = {exp_status, st};
    exp_enabled = {exp_enabled, en};
    exp_read    = {exp_read, rd};
  endfunction

  function void check_result(logic [1:0] st, logic [15:0] en, logic [7:0] rd);
    if (exp_status.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    if (st !== exp_status[0]) begin
      $error("status exp %0d got %0d", exp_status[0], st); errors++;
    end
    if (en !== exp_enabled[0]) begin
      $error("enabled_set exp %h got %h", exp_enabled[0], en); errors++;
    end
    if (rd !== exp_read[0]) begin
      $error("token_read exp %0d got %0d", exp_read[0], rd); errors++;
    end
    void'(exp_status.pop_front());
    void'(exp_enabled.pop_front());
    void'(exp_read.pop_front());
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module tb_petri_net_firing_engine_unit;
  import pnfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [3:0]  in_trans_index = '0;
  logic [3:0]  in_place_index = '0;
  logic [15:0] in_pre_mask = '0;
  logic [15:0] in_context_mask = '0;
  logic [15:0] in_post_mask = '0;
  logic [7:0]  in_token_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_enabled_set;
  logic [7:0]  out_token_read;

  // Idle/stall chance in percent, changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  marking_scoreboard sb = new();

  always #1 clk = ~clk;

  petri_net_firing_engine_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_trans_index  (in_trans_index),
    .in_place_index  (in_place_index),
    .in_pre_mask     (in_pre_mask),
    .in_context_mask (in_context_mask),
    .in_post_mask    (in_post_mask),
    .in_token_value  (in_token_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_enabled_set (out_enabled_set),
    .out_token_read  (out_token_read)
  );

  // Input beats are noted in the scoreboard when accepted, results checked
  // when accepted; both sampled at the edge with pre-edge values.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_op, in_trans_index, in_place_index, in_pre_mask,
                    in_context_mask, in_post_mask, in_token_value);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_enabled_set, out_token_read);
  end

  // Receiver: stalls at random per the current phase.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one beat: optional idle gap first, then hold until accepted.
  task automatic send_beat(logic [2:0] op, logic [3:0] t, logic [3:0] p,
                           logic [15:0] pre, logic [15:0] ctx,
                           logic [15:0] post, logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_trans_index  <= t;
    in_place_index  <= p;
    in_pre_mask     <= pre;
    in_context_mask <= ctx;
    in_post_mask    <= post;
    in_token_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sparse random mask: most masks set one to three places per arc set.
  function automatic logic [15:0] sparse_mask();
    logic [15:0] m;
    m = '0;
    case ($urandom_range(9))
      0:       m = 16'($urandom);
      1:       m = '0;
      default: for (int k = int'($urandom_range(1, 3)); k > 0; k--)
                 m[4'($urandom_range(15))] = 1'b1;
    endcase
    return m;
  endfunction

  task automatic random_beat();
    int unsigned r;
    logic [7:0] v;
    r = $urandom_range(99);
    v = ($urandom_range(9) == 0) ? 8'(($urandom_range(1) != 0) ? 8'hff : 8'hfe)
                                 : 8'($urandom_range(3));
    if ($urandom_range(19) == 0) v = 8'($urandom);
    if (r < 12)
      send_beat(OP_LOAD, 4'($urandom), 4'($urandom), sparse_mask(), sparse_mask(),
                sparse_mask(), 8'($urandom));
    else if (r < 30)
      send_beat(OP_WRITE, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), v);
    else if (r < 42)
      send_beat(OP_READ, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 8'($urandom));
    else if (r < 88)
      send_beat(OP_FIRE, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 8'($urandom));
    else if (r < 95)
      send_beat(OP_QUERY, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 8'($urandom));
    else
      send_beat(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-ones masks, empty net, refused and saturating fires.
    send_beat(OP_QUERY, 4'h0, 4'h0, '0, '0, '0, '0);
    send_beat(OP_FIRE, 4'hf, 4'h0, '0, '0, '0, '0);          // empty arcs: fires
    send_beat(OP_LOAD, 4'hf, 4'h0, 16'hffff, 16'hffff, 16'hffff, 8'hff);
    send_beat(OP_FIRE, 4'hf, 4'h0, '0, '0, '0, '0);          // not enabled
    send_beat(OP_LOAD, 4'h0, 4'h0, 16'h0001, 16'h0002, 16'h8001, 8'h00);
    send_beat(OP_WRITE, 4'h0, 4'h0, '0, '0, '0, 8'd1);
    send_beat(OP_FIRE, 4'h0, 4'h0, '0, '0, '0, '0);          // read arc empty
    send_beat(OP_WRITE, 4'h0, 4'h1, '0, '0, '0, 8'd5);
    send_beat(OP_WRITE, 4'h0, 4'hf, '0, '0, '0, 8'hff);
    send_beat(OP_FIRE, 4'h0, 4'h0, '0, '0, '0, '0);          // saturate p15
    send_beat(OP_READ, 4'h0, 4'h0, '0, '0, '0, '0);          // consumed+produced
    send_beat(OP_READ, 4'h0, 4'h1, '0, '0, '0, '0);          // read arc intact
    send_beat(OP_READ, 4'h0, 4'hf, '0, '0, '0, '0);
    for (int p = 0; p < 16; p++)
      send_beat(OP_WRITE, 4'h0, 4'(p), '0, '0, '0, 8'hff);
    send_beat(OP_FIRE, 4'hf, 4'h0, '0, '0, '0, '0);
    send_beat(3'd7, 4'hf, 4'hf, 16'hffff, 16'hffff, 16'hffff, 8'hff);
    send_beat(3'd5, 4'h0, 4'h0, '0, '0, '0, '0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        3: begin send_idle_pct = 36; recv_stall_pct = 36; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 340; n++) random_beat();
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_petri_net_firing_engine_unit: PASS");
    else
      $display("tb_petri_net_firing_engine_unit: FAIL");
    $finish;
  end

  // Watchdog: bounds a run of about 1700 items with stalls, with a wide margin.
  initial begin
    #2000000;
    $display("tb_petri_net_firing_engine_unit: FAIL");
    $finish;
  end
endmodule

`default_nettype wire
